// ===== rtl/dtw_cumulative_cost_core_assert.svh =====
// assertion macros shared by the dtw cumulative cost modules
`ifndef DTW_CUMULATIVE_COST_CORE_ASSERT_SVH
`define DTW_CUMULATIVE_COST_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define DTWC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtwc assertion failed");
// next-cycle implication
`define DTWC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtwc assertion failed");
`else
`define DTWC_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTWC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dtwc_pkg.sv =====
// shared types and constants of the dtw cumulative cost core
`timescale 1ns / 1ps
package dtwc_pkg;

   localparam int COST_W          = 16;
   localparam int DIAG_WEIGHT_W   = 9;
   localparam int DIAG_WEIGHT     = 361;
   localparam int PROD_W          = COST_W + DIAG_WEIGHT_W;
   localparam int ROUND_HALF      = 128;
   localparam int DIAG_SHIFT      = 8;
   localparam int DIAG_W          = PROD_W - DIAG_SHIFT;
   localparam int OUT_W           = 32;
   localparam int COLUMN_COUNT_W  = 11;
   localparam int ROW_COUNT_W     = 16;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam int DEFAULT_MAX_COLUMNS = 1024;
   localparam int DEFAULT_SUM_WIDTH   = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMN_COUNT = 4'd0,
      CSR_ROW_COUNT    = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic first_row;
      logic first_col;
      logic final_cell;
   } cell_flags_type;

endpackage

// ===== rtl/dtwc_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module dtwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dtwc_queue.sv =====
// small register queue between the front and back parts
`timescale 1ns / 1ps
module dtwc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/dtwc_front.sv =====
// front part: config registers, cell position tracking and diagonal weighting
`timescale 1ns / 1ps
`include "dtw_cumulative_cost_core_assert.svh"
module dtwc_front #(
   parameter int MAX_COLUMNS = dtwc_pkg::DEFAULT_MAX_COLUMNS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dtwc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dtwc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dtwc_pkg::COST_W-1:0]       req_cell_cost,
   output logic                              q_valid,
   input  logic                              q_ready,
   output dtwc_pkg::cell_flags_type          q_flags,
   output logic [dtwc_pkg::COST_W-1:0]       q_cost,
   output logic [dtwc_pkg::DIAG_W-1:0]       q_diag,
   output logic [$clog2(MAX_COLUMNS)-1:0]    q_col
);
   import dtwc_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int LW    = (COL_W + 1 > COLUMN_COUNT_W) ? COL_W + 1 : COLUMN_COUNT_W;

   logic [COLUMN_COUNT_W-1:0] column_count_ff;
   logic [ROW_COUNT_W-1:0]    row_count_ff;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_COUNT_W-1:0]    row_ff, row_in;
   logic                      f_valid_ff, f_valid_in;
   logic [COST_W-1:0]         f_cost_ff;
   logic [PROD_W-1:0]         f_prod_ff;
   logic [COL_W-1:0]          f_col_ff;
   cell_flags_type            f_flags_ff;
   cell_flags_type            flags_in;

   logic [LW-1:0]             cols_raw, eff_cols;
   logic [ROW_COUNT_W-1:0]    eff_rows;
   logic                      last_col, last_row, accept;
   logic [PROD_W-1:0]         rounded;

   assign csr_ready = 1'b1;
   assign req_ready = !f_valid_ff || q_ready;
   assign accept    = req_valid && req_ready;

   // out-of-range counts clamp to the usable range
   always_comb begin
      cols_raw = LW'(column_count_ff);
      if (cols_raw == '0) begin
         eff_cols = LW'(1);
      end else if (cols_raw > LW'(MAX_COLUMNS)) begin
         eff_cols = LW'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_raw;
      end
      eff_rows = (row_count_ff == '0) ? ROW_COUNT_W'(1) : row_count_ff;
      last_col = (LW'(col_ff) + LW'(1)) >= eff_cols;
      last_row = ({1'b0, row_ff} + (ROW_COUNT_W + 1)'(1)) >= {1'b0, eff_rows};

      flags_in.first_row  = (row_ff == '0);
      flags_in.first_col  = (col_ff == '0);
      flags_in.final_cell = last_col && last_row;
   end

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      f_valid_in = f_valid_ff;
      if (q_ready) begin
         f_valid_in = 1'b0;
      end
      if (accept) begin
         f_valid_in = 1'b1;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_W'(1);
         row_count_ff    <= ROW_COUNT_W'(1);
         col_ff          <= '0;
         row_ff          <= '0;
         f_valid_ff      <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         f_valid_ff <= f_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[COLUMN_COUNT_W-1:0];
               CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[ROW_COUNT_W-1:0];
               default:          ;
            endcase
         end
      end
   end

   // cost times the diagonal weight, registered before rounding
   always_ff @(posedge clock) begin
      if (accept) begin
         f_cost_ff  <= req_cell_cost;
         f_prod_ff  <= PROD_W'(req_cell_cost) * PROD_W'(DIAG_WEIGHT);
         f_col_ff   <= col_ff;
         f_flags_ff <= flags_in;
      end
   end

   // round half up, then drop the fraction of the weight
   assign rounded = f_prod_ff + PROD_W'(ROUND_HALF);

   assign q_valid = f_valid_ff;
   assign q_flags = f_flags_ff;
   assign q_cost  = f_cost_ff;
   assign q_diag  = rounded[PROD_W-1:DIAG_SHIFT];
   assign q_col   = f_col_ff;

   `DTWC_ASSERT_NXT(a_rearm_after_final, clock, reset, accept && flags_in.final_cell, (col_ff == '0) && (row_ff == '0))
   `DTWC_ASSERT_NXT(a_accept_loads_stage, clock, reset, accept, f_valid_ff)
   `DTWC_ASSERT_NXT(a_col_steps, clock, reset, accept && !last_col, col_ff == $past(col_ff) + 1'b1)

endmodule

// ===== rtl/dtwc_back.sv =====
// back part: line buffer, cumulative cost recurrence and result register
`timescale 1ns / 1ps
`include "dtw_cumulative_cost_core_assert.svh"
module dtwc_back #(
   parameter int MAX_COLUMNS = dtwc_pkg::DEFAULT_MAX_COLUMNS,
   parameter int SUM_WIDTH   = dtwc_pkg::DEFAULT_SUM_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  dtwc_pkg::cell_flags_type          q_flags,
   input  logic [dtwc_pkg::COST_W-1:0]       q_cost,
   input  logic [dtwc_pkg::DIAG_W-1:0]       q_diag,
   input  logic [$clog2(MAX_COLUMNS)-1:0]    q_col,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dtwc_pkg::OUT_W-1:0]        rsp_cumulative_cost,
   output logic                              rsp_final_cell
);
   import dtwc_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);

   function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                    input logic [SUM_WIDTH-1:0] b);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
   endfunction

   logic                  b_valid_ff, b_valid_in;
   logic                  byp_ff;
   cell_flags_type        b_flags_ff;
   logic [COST_W-1:0]     b_cost_ff;
   logic [DIAG_W-1:0]     b_diag_ff;
   logic [COL_W-1:0]      b_col_ff;
   logic [SUM_WIDTH-1:0]  left_ff, upleft_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_cost_ff;
   logic                  rsp_final_ff;

   logic                  b_fire, q_pop;
   logic [SUM_WIDTH-1:0]  ram_rd_data, up, cost_w, diag_w;
   logic [SUM_WIDTH-1:0]  left_sum, up_sum, diag_sum, min_lu, value;
   logic [SUM_WIDTH+OUT_W-1:0] value_wide;
   logic [OUT_W-1:0]      value_out;

   assign b_fire  = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign q_ready = !b_valid_ff || b_fire;
   assign q_pop   = q_valid && q_ready;

   dtwc_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (MAX_COLUMNS)
   ) u_line (
      .clock   (clock),
      .wr_en   (b_fire),
      .wr_addr (b_col_ff),
      .wr_data (value),
      .rd_en   (q_pop),
      .rd_addr (q_col),
      .rd_data (ram_rd_data)
   );

   // one column: the cell above was just produced and sits in left_ff
   assign up     = byp_ff ? left_ff : ram_rd_data;
   assign cost_w = SUM_WIDTH'(b_cost_ff);
   assign diag_w = SUM_WIDTH'(b_diag_ff);

   always_comb begin
      left_sum = sat_add(left_ff, cost_w);
      up_sum   = sat_add(up, cost_w);
      diag_sum = sat_add(upleft_ff, diag_w);
      min_lu   = (left_sum < up_sum) ? left_sum : up_sum;
      if (b_flags_ff.first_row && b_flags_ff.first_col) begin
         value = cost_w;
      end else if (b_flags_ff.first_row) begin
         value = left_sum;
      end else if (b_flags_ff.first_col) begin
         value = up_sum;
      end else begin
         value = (min_lu < diag_sum) ? min_lu : diag_sum;
      end
      value_wide = {OUT_W'(0), value};
      value_out  = (|value_wide[SUM_WIDTH+OUT_W-1:OUT_W]) ? '1 : value_wide[OUT_W-1:0];
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_fire) begin
         b_valid_in = 1'b0;
      end
      if (q_pop) begin
         b_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (b_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         upleft_ff    <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            byp_ff <= b_fire && (b_col_ff == q_col);
         end else if (b_fire) begin
            byp_ff <= 1'b0;
         end
         if (b_fire) begin
            left_ff   <= value;
            upleft_ff <= b_flags_ff.first_row ? '0 : up;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_flags_ff <= q_flags;
         b_cost_ff  <= q_cost;
         b_diag_ff  <= q_diag;
         b_col_ff   <= q_col;
      end
      if (b_fire) begin
         rsp_cost_ff  <= value_out;
         rsp_final_ff <= b_flags_ff.final_cell;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cumulative_cost = rsp_cost_ff;
   assign rsp_final_cell      = rsp_final_ff;

   `DTWC_ASSERT_IMP(a_bypass_needs_item, clock, reset, byp_ff, b_valid_ff)
   `DTWC_ASSERT_NXT(a_pop_fills_stage, clock, reset, q_pop, b_valid_ff)
   `DTWC_ASSERT_IMP(a_inner_is_min, clock, reset, b_fire && !b_flags_ff.first_row && !b_flags_ff.first_col, (value <= left_sum) && (value <= up_sum) && (value <= diag_sum))

endmodule

// ===== rtl/dtw_cumulative_cost_core.sv =====
// top level of the streaming dtw cumulative cost core
//
//  channel   direction  handshake            payload
//  csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//  req_      in         req_valid/req_ready  req_cell_cost (8.8)
//  rsp_      out        rsp_valid/rsp_ready  rsp_cumulative_cost (24.8), rsp_final_cell
//
// sustained rate is one cell per cycle while rsp_ready stays high, set by the
// left-neighbor recurrence in the back part (three saturating adds and a min)
// rsp_valid rises once an accepted cell has passed the front register (loaded at the
// req accepting edge), then queue, line-buffer read stage and result register
// synchronous active-high reset clears control state and sets both counts to 1;
// the line buffer needs no clearing pass
// a stalled rsp side holds the result register; the queue and front register
// keep taking items until full, then req_ready drops
`timescale 1ns / 1ps
module dtw_cumulative_cost_core #(
   parameter int MAX_COLUMNS = dtwc_pkg::DEFAULT_MAX_COLUMNS,
   parameter int SUM_WIDTH   = dtwc_pkg::DEFAULT_SUM_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dtwc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtwc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // cost cells in row-major order
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [dtwc_pkg::COST_W-1:0]      req_cell_cost,
   // cumulative costs, one per cell
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dtwc_pkg::OUT_W-1:0]       rsp_cumulative_cost,
   output logic                             rsp_final_cell
);
   import dtwc_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int QW    = $bits(cell_flags_type) + COST_W + DIAG_W + COL_W;

   // front to queue
   logic                 fq_valid, fq_ready;
   cell_flags_type       fq_flags;
   logic [COST_W-1:0]    fq_cost;
   logic [DIAG_W-1:0]    fq_diag;
   logic [COL_W-1:0]     fq_col;
   logic [QW-1:0]        fq_data;

   // queue to back
   logic                 qb_valid, qb_ready;
   logic [QW-1:0]        qb_data;
   cell_flags_type       qb_flags;
   logic [COST_W-1:0]    qb_cost;
   logic [DIAG_W-1:0]    qb_diag;
   logic [COL_W-1:0]     qb_col;

   // front: position counters, first row / first column / final cell tags,
   // cost times 361 registered before rounding to the diagonal cost
   dtwc_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_cost (req_cell_cost),
      .q_valid       (fq_valid),
      .q_ready       (fq_ready),
      .q_flags       (fq_flags),
      .q_cost        (fq_cost),
      .q_diag        (fq_diag),
      .q_col         (fq_col)
   );

   assign fq_data = {fq_flags, fq_cost, fq_diag, fq_col};

   // decouples the two parts so either can stall alone
   dtwc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   assign {qb_flags, qb_cost, qb_diag, qb_col} = qb_data;

   // back: previous-row line buffer read, min of the three candidates,
   // write-back and result register
   dtwc_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .SUM_WIDTH   (SUM_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (qb_valid),
      .q_ready             (qb_ready),
      .q_flags             (qb_flags),
      .q_cost              (qb_cost),
      .q_diag              (qb_diag),
      .q_col               (qb_col),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cumulative_cost (rsp_cumulative_cost),
      .rsp_final_cell      (rsp_final_cell)
   );

endmodule
